### sv/msdft_pkg.sv
`default_nettype none

package msdft_pkg;

  localparam int WINDOW_LEN   = 128;
  localparam int CHANNELS_DEF = 4;
  localparam int NUM_HARM     = 4;
  localparam int PTR_W        = $clog2(WINDOW_LEN);
  localparam int PHASE_W      = 7;
  localparam int SAMPLE_W     = 16;
  localparam int CHAN_W       = 2;
  localparam int FREQ_W       = 12;
  localparam int ACC_W        = 32;
  localparam int COS_W        = 14;
  localparam int BASE_W       = 7;
  localparam int INC_W        = 10;
  localparam int DC_SHIFT     = 11;
  localparam int HALF_BAND    = 64;
  localparam int FREQ_RECIP   = 1311;  // round-up of 2^16 / 50
  localparam int FREQ_SHIFT   = 16;
  localparam int PROD_W       = FREQ_SHIFT + BASE_W;

  localparam logic [FREQ_W-1:0] FUND_FREQ_RST = FREQ_W'(50);

  // floor(4096 * cos(2*pi*k/128)), first quarter
  localparam logic signed [COS_W-1:0] QCOS [33] = '{
    14'sd4096, 14'sd4091, 14'sd4076, 14'sd4051, 14'sd4017, 14'sd3973, 14'sd3919, 14'sd3856,
    14'sd3784, 14'sd3702, 14'sd3612, 14'sd3513, 14'sd3405, 14'sd3289, 14'sd3166, 14'sd3034,
    14'sd2896, 14'sd2750, 14'sd2598, 14'sd2439, 14'sd2275, 14'sd2105, 14'sd1930, 14'sd1751,
    14'sd1567, 14'sd1379, 14'sd1189, 14'sd995,  14'sd799,  14'sd601,  14'sd401,  14'sd200,
    14'sd0
  };

  typedef struct packed {
    logic                                valid;
    logic                                in_range;
    logic [CHAN_W-1:0]                   chan;
    logic signed [SAMPLE_W-1:0]          sample;
    logic                                filled;
    logic [NUM_HARM-1:0][PHASE_W-1:0]    phase;
    logic [NUM_HARM-1:0]                 upd;
  } s1_t;

  typedef struct packed {
    logic [ACC_W-1:0]                    energy;
    logic [ACC_W-1:0]                    dc;
    logic [NUM_HARM-1:0][ACC_W-1:0]      re;
    logic [NUM_HARM-1:0][ACC_W-1:0]      im;
  } res_t;

  // fund_freq / 50 by reciprocal multiply, exact over the 12-bit range
  function automatic logic [BASE_W-1:0] freq_base(input logic [FREQ_W-1:0] f);
    logic [PROD_W-1:0] p;
    p = PROD_W'(f) * PROD_W'(FREQ_RECIP);
    return p[FREQ_SHIFT +: BASE_W];
  endfunction

  function automatic logic signed [COS_W-1:0] cos_rom(input logic [PHASE_W-1:0] i);
    logic [PHASE_W-1:0] j;
    logic signed [COS_W-1:0] r;
    j = '0;
    if (i <= 7'd32) begin
      r = QCOS[6'(i)];
    end else if (i < 7'd64) begin
      j = 7'd64 - i;
      r = -QCOS[6'(j)] - 14'sd1;
    end else if (i == 7'd64) begin
      r = -14'sd4096;
    end else if (i < 7'd96) begin
      j = i - 7'd64;
      r = -QCOS[6'(j)] - 14'sd1;
    end else if (i == 7'd96) begin
      r = '0;
    end else begin
      j = 7'd0 - i;
      r = QCOS[6'(j)];
    end
    return r;
  endfunction

  function automatic logic signed [COS_W-1:0] sin_rom(input logic [PHASE_W-1:0] i);
    return cos_rom(i - 7'd32);
  endfunction

endpackage

`default_nettype wire

### sv/msdft_delay_ram.sv
`default_nettype none

module msdft_delay_ram #(
  parameter int DEPTH  = msdft_pkg::CHANNELS_DEF * msdft_pkg::WINDOW_LEN,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = msdft_pkg::SAMPLE_W
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read-first: the old sample comes out as the new one goes in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mem_q[addr_i] <= wdata_i;
      rdata_q       <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/msdft_front.sv
`default_nettype none

module msdft_front #(
  parameter int CHANNELS = msdft_pkg::CHANNELS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [msdft_pkg::FREQ_W-1:0]          cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  input  wire logic [msdft_pkg::CHAN_W-1:0]          in_chan_i,
  input  wire logic signed [msdft_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                                       in_ready_o,
  input  wire logic                                  adv_i,
  output msdft_pkg::s1_t                             s1_o,
  output logic signed [msdft_pkg::SAMPLE_W-1:0]      old_o
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = CH_W + msdft_pkg::PTR_W;
  localparam int DEPTH  = CHANNELS * msdft_pkg::WINDOW_LEN;
  localparam int NH     = msdft_pkg::NUM_HARM;
  localparam int PW     = msdft_pkg::PHASE_W;

  logic [msdft_pkg::BASE_W-1:0] base_q;
  logic [msdft_pkg::PTR_W-1:0]  wp_q     [CHANNELS];
  logic                         filled_q [CHANNELS];
  logic [PW-1:0]                phase_q  [CHANNELS][NH];
  msdft_pkg::s1_t               s1_q, s1_d;

  logic                         accept;
  logic                         in_range;
  logic                         wr;
  logic [CH_W-1:0]              ch_idx;
  logic [msdft_pkg::INC_W-1:0]  inc   [NH];
  logic [NH-1:0]                upd;
  logic [NH-1:0][PW-1:0]        p_new;
  logic [msdft_pkg::SAMPLE_W-1:0] rdata;

  assign in_ready_o = !s1_q.valid || adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 32'(in_chan_i) < CHANNELS;
  assign wr         = accept && in_range;
  assign ch_idx     = CH_W'(in_chan_i);

  always_comb begin
    for (int k = 0; k < NH; k++) begin
      inc[k]   = msdft_pkg::INC_W'(base_q) * msdft_pkg::INC_W'(2 * k + 1);
      upd[k]   = inc[k] < msdft_pkg::INC_W'(msdft_pkg::HALF_BAND);
      p_new[k] = phase_q[ch_idx][k] + inc[k][PW-1:0];
    end
  end

  always_comb begin
    s1_d = s1_q;
    // an empty stage takes a beat even while the output is held
    if (in_ready_o) begin
      s1_d.valid = accept;
    end
    if (accept) begin
      s1_d.in_range = in_range;
      s1_d.chan     = in_chan_i;
      s1_d.sample   = in_sample_i;
      s1_d.filled   = filled_q[ch_idx];
      s1_d.phase    = p_new;
      s1_d.upd      = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      base_q <= msdft_pkg::freq_base(msdft_pkg::FUND_FREQ_RST);
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]     <= '0;
        filled_q[c] <= 1'b0;
        for (int k = 0; k < NH; k++) begin
          phase_q[c][k] <= '0;
        end
      end
    end else begin
      s1_q <= s1_d;
      if (cfg_we_i) begin
        base_q <= msdft_pkg::freq_base(cfg_wdata_i);
      end
      if (wr) begin
        wp_q[ch_idx] <= wp_q[ch_idx] + 1'b1;
        // every slot of the window holds a real sample once the pointer wraps
        if (&wp_q[ch_idx]) begin
          filled_q[ch_idx] <= 1'b1;
        end
        for (int k = 0; k < NH; k++) begin
          if (upd[k]) begin
            phase_q[ch_idx][k] <= p_new[k];
          end
        end
      end
    end
  end

  msdft_delay_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (msdft_pkg::SAMPLE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (wr),
    .addr_i  ({ch_idx, wp_q[ch_idx]}),
    .wdata_i (in_sample_i),
    .rdata_o (rdata)
  );

  assign s1_o  = s1_q;
  assign old_o = rdata;

endmodule

`default_nettype wire

### sv/msdft_back.sv
`default_nettype none

module msdft_back #(
  parameter int CHANNELS = msdft_pkg::CHANNELS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire msdft_pkg::s1_t                        s1_i,
  input  wire logic signed [msdft_pkg::SAMPLE_W-1:0] old_i,
  output logic                                       adv_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [msdft_pkg::CHAN_W-1:0]               out_chan_o,
  output msdft_pkg::res_t                            out_res_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NH   = msdft_pkg::NUM_HARM;
  localparam int AW   = msdft_pkg::ACC_W;
  localparam int SW   = msdft_pkg::SAMPLE_W;
  localparam int CW   = SW + 1;
  localparam int MW   = CW + msdft_pkg::COS_W;

  logic [AW-1:0] energy_q [CHANNELS];
  logic [AW-1:0] dc_q     [CHANNELS];
  logic [AW-1:0] re_q     [CHANNELS][NH];
  logic [AW-1:0] im_q     [CHANNELS][NH];

  logic                      out_valid_q;
  logic [msdft_pkg::CHAN_W-1:0] out_chan_q;
  msdft_pkg::res_t           out_res_q;

  logic [CH_W-1:0]           ch;
  logic                      take;
  logic                      commit;
  logic signed [SW-1:0]      old;
  logic signed [CW-1:0]      comb;
  logic signed [2*SW-1:0]    sq_new, sq_old;
  logic signed [MW-1:0]      prod_re [NH];
  logic signed [MW-1:0]      prod_im [NH];
  msdft_pkg::res_t           upd_res;

  assign adv_o  = !out_valid_q || out_ready_i;
  assign take   = adv_o && s1_i.valid;
  assign commit = take && s1_i.in_range;
  assign ch     = CH_W'(s1_i.chan);

  // unwritten slots of a fresh window read as zero
  assign old  = s1_i.filled ? old_i : '0;
  assign comb = CW'(s1_i.sample) - CW'(old);

  always_comb begin
    sq_new = s1_i.sample * s1_i.sample;
    sq_old = old * old;
    upd_res.energy = energy_q[ch] + AW'(sq_new) - AW'(sq_old);
    upd_res.dc     = dc_q[ch] + (AW'(comb) << msdft_pkg::DC_SHIFT);
    for (int k = 0; k < NH; k++) begin
      prod_re[k] = comb * msdft_pkg::cos_rom(s1_i.phase[k]);
      prod_im[k] = comb * msdft_pkg::sin_rom(s1_i.phase[k]);
      if (s1_i.upd[k]) begin
        upd_res.re[k] = re_q[ch][k] + AW'(prod_re[k]);
        upd_res.im[k] = im_q[ch][k] - AW'(prod_im[k]);
      end else begin
        upd_res.re[k] = re_q[ch][k];
        upd_res.im[k] = im_q[ch][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        energy_q[c] <= '0;
        dc_q[c]     <= '0;
        for (int k = 0; k < NH; k++) begin
          re_q[c][k] <= '0;
          im_q[c][k] <= '0;
        end
      end
    end else begin
      if (adv_o) begin
        out_valid_q <= s1_i.valid;
      end
      if (commit) begin
        energy_q[ch] <= upd_res.energy;
        dc_q[ch]     <= upd_res.dc;
        for (int k = 0; k < NH; k++) begin
          re_q[ch][k] <= upd_res.re[k];
          im_q[ch][k] <= upd_res.im[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_chan_q <= s1_i.chan;
      out_res_q  <= s1_i.in_range ? upd_res : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chan_o  = out_chan_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

### sv/msdft_odd_harmonic_tracker.sv
`default_nettype none
// A beat is registered in s1, then in the output register. Throughput: one beat per
// cycle unless the output stalls, any channel order, back to back on the same channel.
// The delay-line RAM reads the old sample and writes the new one in the same cycle.
// Reset clears pointers, phases and accumulators at once and sets fund_freq to 50; the
// delay line is not swept, a per-channel fill flag masks slots not yet written.

module msdft_odd_harmonic_tracker #(
  parameter int CHANNELS = msdft_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [msdft_pkg::FREQ_W-1:0]  cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [15:0] sample
  input  wire logic [1:0]                    s_axis_tuser,  // [1:0] chan
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [31:0] energy_sum, [63:32] dc_sum, [95:64] h1_re, [127:96] h1_im, [159:128] h3_re,
  // [191:160] h3_im, [223:192] h5_re, [255:224] h5_im, [287:256] h7_re, [319:288] h7_im
  output logic [319:0]                       m_axis_tdata,
  output logic [1:0]                         m_axis_tuser   // [1:0] chan_out
);

  localparam int AW = msdft_pkg::ACC_W;

  msdft_pkg::s1_t  s1;
  msdft_pkg::res_t res;
  logic            adv;
  logic signed [msdft_pkg::SAMPLE_W-1:0] old;

  msdft_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_chan_i   (s_axis_tuser),
    .in_sample_i (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .adv_i       (adv),
    .s1_o        (s1),
    .old_o       (old)
  );

  msdft_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1),
    .old_i       (old),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_chan_o  (m_axis_tuser),
    .out_res_o   (res)
  );

  always_comb begin
    m_axis_tdata[0 +: AW]  = res.energy;
    m_axis_tdata[AW +: AW] = res.dc;
    for (int k = 0; k < msdft_pkg::NUM_HARM; k++) begin
      m_axis_tdata[AW * (2 + 2 * k) +: AW] = res.re[k];
      m_axis_tdata[AW * (3 + 2 * k) +: AW] = res.im[k];
    end
  end

`ifndef NO_ASSERTIONS
  // input side stalls only behind a full stage and a held output beat
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1.valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked output");

  // a staged beat moves into the output register whenever it is free
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1.valid && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
    else $error("staged beat not forwarded");

  // channels outside the configured range report all-zero accumulators
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (32'(m_axis_tuser) >= CHANNELS)) |-> (m_axis_tdata == '0))
    else $error("out-of-range channel with nonzero data");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PER_PHASE = 126;
  localparam int RAND_PHASES    = 15;
  localparam int QUIET_LIMIT    = 2000;

  typedef struct packed {
    logic [1:0]       chan;
    logic [31:0]      energy_sum;
    logic [31:0]      dc_sum;
    logic [0:3][31:0] h_re;  // harmonics 1, 3, 5, 7
    logic [0:3][31:0] h_im;
  } tracker_out_t;

  typedef struct packed {
    logic [1:0]   chan;
    logic [15:0]  smp;
    logic         typed;
    tracker_out_t want;
  } sample_row_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

  localparam int QTR_COS [33] = '{
    4096, 4091, 4076, 4051, 4017, 3973, 3919, 3856,
    3784, 3702, 3612, 3513, 3405, 3289, 3166, 3034,
    2896, 2750, 2598, 2439, 2275, 2105, 1930, 1751,
    1567, 1379, 1189,  995,  799,  601,  401,  200,
    0
  };

  // Settings swept after the reset value: they freeze different sets of harmonics, from none to all.
  localparam logic [11:0] FREQ_PLAN [12] = '{
    12'd0, 12'd4095, 12'd449, 12'd450, 12'd500, 12'd649,
    12'd650, 12'd1050, 12'd1100, 12'd3199, 12'd3200, 12'd50
  };

  // Fund_freq stays at its reset value here, so base increment is 1.
  sample_row_t directed_rows [16] = '{
    '{2'd0, 16'h7FFF, 1'b1, '{2'd0, 32'd1073676289, 32'd67106816,
      '{32'd134049797, 32'd132739117, 32'd130183291, 32'd126349552},
      '{-32'sd6553400, -32'sd19692967, -32'sd32603165, -32'sd45185693}}},
    '{2'd1, 16'h8000, 1'b1, '{2'd1, 32'd1073741824, -32'sd67108864,
      '{-32'sd134053888, -32'sd132743168, -32'sd130187264, -32'sd126353408},
      '{32'd6553600, 32'd19693568, 32'd32604160, 32'd45187072}}},
    '{2'd2, 16'h0000, 1'b1, '{2'd2, 32'd0, 32'd0,
      '{32'd0, 32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0, 32'd0}}},
    '{2'd3, 16'h0001, 1'b1, '{2'd3, 32'd1, 32'd2048,
      '{32'd4091, 32'd4051, 32'd3973, 32'd3856},
      '{-32'sd200, -32'sd601, -32'sd995, -32'sd1379}}},
    '{2'd0, 16'h8000, 1'b0, '0},
    '{2'd0, 16'h5555, 1'b0, '0},
    '{2'd0, 16'hAAAA, 1'b0, '0},
    '{2'd1, 16'h7FFF, 1'b0, '0},
    '{2'd1, 16'hFFFF, 1'b0, '0},
    '{2'd2, 16'hFFFF, 1'b0, '0},
    '{2'd3, 16'h8000, 1'b0, '0},
    '{2'd3, 16'h7FFF, 1'b0, '0},
    '{2'd2, 16'h00FF, 1'b0, '0},
    '{2'd1, 16'hFF00, 1'b0, '0},
    '{2'd0, 16'h0000, 1'b0, '0},
    '{2'd3, 16'hFFFE, 1'b0, '0}
  };

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [msdft_pkg::FREQ_W-1:0] cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata  = '0;
  logic [1:0]                   s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [319:0]                 m_axis_tdata;
  logic [1:0]                   m_axis_tuser;

  // Side info that travels with the beat on the bus
  logic         row_typed = 1'b0;
  tracker_out_t row_want  = '0;

  // Predictor state, one copy per channel
  logic signed [15:0] win_mem [4][128] = '{default: '0};
  logic [6:0]         win_ptr [4]      = '{default: '0};
  int                 energy_q [4]     = '{default: 0};
  int                 dc_q [4]         = '{default: 0};
  int                 re_q [4][4]      = '{default: 0};
  int                 im_q [4][4]      = '{default: 0};
  logic [6:0]         ph_q [4][4]      = '{default: '0};
  logic [11:0]        freq_shadow      = 12'd50;

  tracker_out_t awaited_sums [$];
  int           errors        = 0;
  int           samples_in    = 0;
  int           results_seen  = 0;
  int           settings_used = 0;
  int           burst_left    = 0;
  int           quiet_cycles  = 0;
  int           rx_cycle      = 0;
  rx_mode_e     rx_mode       = RX_OPEN;
  logic [7:0]   rx_mask       = 8'b1011_0010;

  msdft_odd_harmonic_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic int q12_cos(input logic [6:0] ph);
    int m;
    m = (ph > 7'd64) ? 128 - ph : ph;  // fold about pi
    if (m == 64) return -4096;
    if (m > 32) return -QTR_COS[64 - m] - 1;
    return QTR_COS[m];
  endfunction

  // Push one sample into the channel window and return its updated sums.
  function automatic tracker_out_t slide_window(input logic [1:0] ch,
                                                input logic signed [15:0] smp);
    tracker_out_t       r;
    logic signed [15:0] oldest;
    int                 comb;
    int                 sq_new;
    int                 sq_old;
    int                 base;
    int                 inc;
    oldest = win_mem[ch][win_ptr[ch]];
    comb   = smp - oldest;
    sq_new = smp * smp;
    sq_old = oldest * oldest;
    energy_q[ch] += sq_new - sq_old;
    dc_q[ch]     += comb << 11;
    win_mem[ch][win_ptr[ch]] = smp;
    win_ptr[ch] = win_ptr[ch] + 7'd1;
    base = freq_shadow / 50;
    for (int k = 0; k < 4; k++) begin
      inc = base * (2 * k + 1);
      // hold harmonics at or above half band
      if (inc < 64) begin
        ph_q[ch][k] = 7'(ph_q[ch][k] + inc);
        re_q[ch][k] += comb * q12_cos(ph_q[ch][k]);
        im_q[ch][k] -= comb * q12_cos(7'(ph_q[ch][k] - 7'd32));
      end
      r.h_re[k] = re_q[ch][k];
      r.h_im[k] = im_q[ch][k];
    end
    r.chan       = ch;
    r.energy_sum = energy_q[ch];
    r.dc_sum     = dc_q[ch];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      errors++;
    end
  endtask

  task automatic send_sample(input logic [1:0] ch, input logic [15:0] smp,
                             input logic typed, input tracker_out_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= smp;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 10);
    end
  endtask

  // Receiver backpressure
  always @(posedge clk_i) begin
    if (rx_cycle % 200 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    rx_cycle++;
    rx_mask = {rx_mask[6:0], rx_mask[7]};
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 9) < 7);
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 9) < 3);
      default:  m_axis_tready <= rx_mask[0];
    endcase
  end

  // Scoreboard: check outgoing beats, then predict incoming ones
  always @(posedge clk_i) begin
    tracker_out_t got;
    tracker_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.chan       = m_axis_tuser;
        got.energy_sum = m_axis_tdata[31:0];
        got.dc_sum     = m_axis_tdata[63:32];
        for (int k = 0; k < 4; k++) begin
          got.h_re[k] = m_axis_tdata[64 * k + 64 +: 32];
          got.h_im[k] = m_axis_tdata[64 * k + 96 +: 32];
        end
        if (awaited_sums.size() == 0) begin
          $error("result beat for channel %0d with nothing pending", got.chan);
          errors++;
        end else begin
          want = awaited_sums.pop_front();
          check_field("chan_out", 32'(want.chan), 32'(got.chan));
          check_field("energy_sum", want.energy_sum, got.energy_sum);
          check_field("dc_sum", want.dc_sum, got.dc_sum);
          for (int k = 0; k < 4; k++) begin
            check_field($sformatf("h%0d_re", 2 * k + 1), want.h_re[k], got.h_re[k]);
            check_field($sformatf("h%0d_im", 2 * k + 1), want.h_im[k], got.h_im[k]);
          end
        end
      end
      if (cfg_we_i) freq_shadow = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        samples_in++;
        want = slide_window(s_axis_tuser, s_axis_tdata);
        awaited_sums.push_back(row_typed ? row_want : want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [1:0]  ch;
    logic [1:0]  hot;
    logic [15:0] smp;
    int          pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 10);
    hot = 2'd0;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].chan, directed_rows[i].smp, directed_rows[i].typed,
                  directed_rows[i].want);
    end
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < RAND_PHASES; p++) begin
      // drain before touching fund_freq
      do @(posedge clk_i); while (awaited_sums.size() != 0);
      cfg_wdata_i <= (p < 12) ? FREQ_PLAN[p] : 12'($urandom_range(0, 4095));
      cfg_we_i    <= 1'b1;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      settings_used++;
      repeat (RAND_PER_PHASE) begin
        if ($urandom_range(0, 7) == 0) hot = 2'($urandom_range(0, 3));
        ch   = $urandom_range(0, 1) ? hot : 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 10) smp = 16'h7FFF;
        else if (pick < 20) smp = 16'h8000;
        else if (pick < 35) smp = 16'($urandom_range(0, 63)) - 16'd32;
        else smp = 16'($urandom);
        send_sample(ch, smp, 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
    end

    do @(posedge clk_i); while (awaited_sums.size() != 0);
    repeat (8) @(posedge clk_i);
    $display("Fed %0d samples on 4 channels under %0d fund_freq settings plus the reset value",
             samples_in, settings_used);
    $display("Compared %0d result beats field by field against the sliding-DFT predictor",
             results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
